// ===== design/assert_macros.svh =====
// Assertion helpers clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bfma_pkg.sv =====
package bfma_pkg;

    localparam int SAMPLE_W = 10;
    localparam int MEAN_W   = 18;
    localparam int SUM_W    = 17;
    localparam int COUNT_W  = 8;

    localparam int STATE_W = 3;
    typedef logic [STATE_W-1:0] state_t;

    localparam state_t S_IDLE = 3'd0;
    localparam state_t S_READ = 3'd1;
    localparam state_t S_DIV  = 3'd2;
    localparam state_t S_DONE = 3'd3;

endpackage

// ===== design/box_filter_moving_average.sv =====
// Moving-average box filter. Each sample request returns one result: the sum of the last
// WINDOW samples (fewer until the window first fills), the number of samples held, and the
// mean with FRAC_BITS fraction bits, truncated. The oldest sample is read from the single-port
// ring memory as the sample request is taken, then the S_READ state updates the sum and count,
// the restoring divider in S_DIV produces one quotient bit per cycle, and S_DONE loads the
// output register. sample_ready is high only while the sequencer is idle, which it is again
// the cycle after the load, so a new sample is not taken before the last one is through. A
// finished result waits in the output register without holding up the next sample request;
// if it is still waiting when the next quotient is done, the sequencer holds until it is taken.
`include "assert_macros.svh"

module box_filter_moving_average #(
    parameter int WINDOW      = 128,
    parameter int SAMPLE_BITS = 10,
    parameter int FRAC_BITS   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [bfma_pkg::SAMPLE_W-1:0] sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [bfma_pkg::MEAN_W-1:0]   mean_value,
    output logic [bfma_pkg::SUM_W-1:0]    window_sum,
    output logic [bfma_pkg::COUNT_W-1:0]  fill_count
);

    import bfma_pkg::*;

    localparam int AW   = $clog2(WINDOW);
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int SUMW = SAMPLE_BITS + AW;
    localparam int QW   = SUMW + FRAC_BITS;
    localparam int ITW  = $clog2(QW + 1);

    logic [SAMPLE_BITS-1:0] mem [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    state_t                 state_reg, state_next;
    logic [SAMPLE_BITS-1:0] s_reg, s_next;
    logic [AW-1:0]          slot_reg, slot_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [SUMW-1:0]        sum_reg, sum_next;
    logic [QW-1:0]          dq_reg, dq_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic [ITW-1:0]         it_reg, it_next;
    logic                   out_valid_reg, out_valid_next;
    logic [QW-1:0]          out_mean_reg, out_mean_next;
    logic [SUMW-1:0]        out_sum_reg, out_sum_next;
    logic [CW-1:0]          out_cnt_reg, out_cnt_next;

    logic [SAMPLE_BITS+SAMPLE_W-1:0] sample_ext;
    logic                            full;
    logic [SUMW-1:0]                 old_term;
    logic [SUMW-1:0]                 upd_sum;
    logic [CW:0]                     shifted;
    logic                            ge;
    logic                            load_out;
    logic [QW+MEAN_W-1:0]            mean_ext;
    logic [SUMW+SUM_W-1:0]           sum_ext;
    logic [CW+COUNT_W-1:0]           cnt_ext;

    assign sample_ext = {{SAMPLE_BITS{1'b0}}, sample};
    assign full       = (cnt_reg >= CW'(WINDOW));
    assign old_term   = full ? {{AW{1'b0}}, rd_data_reg} : '0;
    assign upd_sum    = sum_reg - old_term + {{AW{1'b0}}, s_reg};
    assign shifted    = {rem_reg, dq_reg[QW-1]};
    assign ge         = (shifted >= {1'b0, cnt_reg});
    assign load_out   = (state_reg == S_DONE) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        it_next        = it_reg;
        out_mean_next  = out_mean_reg;
        out_sum_next   = out_sum_reg;
        out_cnt_next   = out_cnt_reg;
        out_valid_next = out_valid_reg && !result_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    s_next     = sample_ext[SAMPLE_BITS-1:0];
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                sum_next   = upd_sum;
                cnt_next   = full ? cnt_reg : cnt_reg + CW'(1);
                slot_next  = (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + AW'(1);
                dq_next    = QW'(upd_sum) << FRAC_BITS;
                rem_next   = '0;
                it_next    = ITW'(QW);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? CW'(shifted - {1'b0, cnt_reg}) : shifted[CW-1:0];
                dq_next  = {dq_reg[QW-2:0], ge};
                it_next  = it_reg - ITW'(1);
                if (it_reg == ITW'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_mean_next  = dq_reg;
                    out_sum_next   = sum_reg;
                    out_cnt_next   = cnt_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Ring memory: read the oldest entry every cycle, overwrite it once the sum is updated.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            mem[slot_reg] <= s_reg;
        end
        rd_data_reg <= mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        it_reg       <= it_next;
        out_mean_reg <= out_mean_next;
        out_sum_reg  <= out_sum_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign mean_ext = {{MEAN_W{1'b0}}, out_mean_reg};
    assign sum_ext  = {{SUM_W{1'b0}}, out_sum_reg};
    assign cnt_ext  = {{COUNT_W{1'b0}}, out_cnt_reg};

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign mean_value   = mean_ext[MEAN_W-1:0];
    assign window_sum   = sum_ext[SUM_W-1:0];
    assign fill_count   = cnt_ext[COUNT_W-1:0];

    `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_reg <= CW'(WINDOW), "fill count above window")
    `ASSERT_NEXT(a_busy_after_req, sample_valid && sample_ready, !sample_ready,
                 "ready held high after sample request")
    `ASSERT_IMPL(a_rem_below_div, state_reg == S_DIV, rem_reg < cnt_reg,
                 "divider remainder not below divisor")
    `ASSERT_IMPL(a_out_cnt_nonzero, out_valid_reg, out_cnt_reg != '0,
                 "result with zero fill count")

endmodule
